[src/intel_hex_record_parser_core_assert.svh]
// assertion macros for the intel hex record parser
`ifndef INTEL_HEX_RECORD_PARSER_CORE_ASSERT_SVH
`define INTEL_HEX_RECORD_PARSER_CORE_ASSERT_SVH

// same-cycle implication
`define IHEXP_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IHEXP_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/ihexp_pkg.sv]
// shared types, codes and helpers for the intel hex record parser
package ihexp_pkg;

    localparam logic [1:0] MODE_RUN  = 2'd0;
    localparam logic [1:0] MODE_DONE = 2'd1;
    localparam logic [1:0] MODE_ERR  = 2'd2;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_REC  = 2'd1;
    localparam logic [1:0] KIND_EOF  = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_LINE      = 3'd1;
    localparam logic [2:0] ERR_HEX       = 3'd2;
    localparam logic [2:0] ERR_SHORT     = 3'd3;
    localparam logic [2:0] ERR_CHECKSUM  = 3'd4;
    localparam logic [2:0] ERR_TYPE      = 3'd5;

    localparam logic [7:0] REC_DATA      = 8'd0;
    localparam logic [7:0] REC_EOF       = 8'd1;
    localparam logic [7:0] REC_EXT_SEG   = 8'd2;
    localparam logic [7:0] REC_START_SEG = 8'd3;
    localparam logic [7:0] REC_EXT_LIN   = 8'd4;
    localparam logic [7:0] REC_START_LIN = 8'd5;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [31:0] byte_address;
        logic        block_start;
        logic [7:0]  rec_type;
        logic [31:0] start_addr;
        logic [2:0]  err_code;
    } result_t;

    typedef struct packed {
        logic       res_vld;
        logic [1:0] mode;
    } eng_stat_t;

    // returns {is_hex, nibble}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= CH_0 && c <= CH_9) begin
            d = c - CH_0;
            return {1'b1, d[3:0]};
        end
        if (c >= CH_UA && c <= CH_UF) begin
            d = c - CH_UA + 8'd10;
            return {1'b1, d[3:0]};
        end
        if (c >= CH_LA && c <= CH_LF) begin
            d = c - CH_LA + 8'd10;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

endpackage

[src/ihexp_engine.sv]
// record parsing state and per-character next-state logic
module ihexp_engine
    import ihexp_pkg::*;
(
    input  logic       clk,
    input  logic       rstn,
    input  logic       fire,
    input  logic [7:0] ch,
    output eng_stat_t  stat,
    output result_t    res
);

    logic [1:0]  mode_reg, mode_next;
    logic [9:0]  pos_reg, pos_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  off_hi_reg, off_hi_next;
    logic [7:0]  kind_reg, kind_next;
    logic [7:0]  sum_reg, sum_next;
    logic [3:0]  hold_reg, hold_next;
    logic [31:0] field_reg, field_next;
    logic [31:0] base_reg, base_next;
    logic [31:0] cur_addr_reg, cur_addr_next;
    logic [31:0] expect_reg, expect_next;
    logic        run_open_reg, run_open_next;
    logic [31:0] start_reg, start_next;

    logic [4:0]  hex_info;
    logic [7:0]  byte_val;
    logic [31:0] addr_inc;
    logic [9:0]  full_pos;
    logic [9:0]  data_end;
    logic        r_vld;
    logic [1:0]  r_kind;
    logic [7:0]  r_data;
    logic [31:0] r_addr;
    logic        r_bs;
    logic [7:0]  r_type;
    logic [2:0]  r_err;

    assign hex_info = hex_decode(ch);
    assign byte_val = {hold_reg, hex_info[3:0]};
    assign addr_inc = cur_addr_reg + 32'd1;
    assign full_pos = 10'd11 + {1'b0, count_reg, 1'b0};
    assign data_end = 10'd8 + {1'b0, count_reg, 1'b0};

    always_comb begin
        mode_next     = mode_reg;
        pos_next      = pos_reg;
        count_next    = count_reg;
        off_hi_next   = off_hi_reg;
        kind_next     = kind_reg;
        sum_next      = sum_reg;
        hold_next     = hold_reg;
        field_next    = field_reg;
        base_next     = base_reg;
        cur_addr_next = cur_addr_reg;
        expect_next   = expect_reg;
        run_open_next = run_open_reg;
        start_next    = start_reg;
        r_vld  = 1'b0;
        r_kind = KIND_DATA;
        r_data = 8'd0;
        r_addr = 32'd0;
        r_bs   = 1'b0;
        r_type = 8'd0;
        r_err  = ERR_NONE;
        if (mode_reg == MODE_RUN) begin
            if (ch == CH_NL) begin
                r_vld = 1'b1;
                if (pos_reg == 10'd0) begin
                    mode_next = MODE_ERR;
                    r_kind    = KIND_ERR;
                    r_err     = ERR_LINE;
                end else if (pos_reg < full_pos) begin
                    mode_next = MODE_ERR;
                    r_kind    = KIND_ERR;
                    r_err     = ERR_SHORT;
                end else if (sum_reg != 8'd0) begin
                    mode_next = MODE_ERR;
                    r_kind    = KIND_ERR;
                    r_err     = ERR_CHECKSUM;
                end else if (kind_reg == REC_EOF) begin
                    pos_next  = 10'd0;
                    mode_next = MODE_DONE;
                    r_kind    = KIND_EOF;
                    r_type    = kind_reg;
                end else if (kind_reg == REC_EXT_SEG || kind_reg == REC_START_SEG) begin
                    mode_next = MODE_ERR;
                    r_kind    = KIND_ERR;
                    r_err     = ERR_TYPE;
                end else begin
                    pos_next = 10'd0;
                    r_kind   = KIND_REC;
                    r_type   = kind_reg;
                    if (kind_reg == REC_EXT_LIN) begin
                        base_next = {field_reg[15:0], 16'd0};
                    end
                    if (kind_reg == REC_START_LIN) begin
                        start_next = field_reg;
                    end
                end
            end else if (pos_reg == 10'd0) begin
                if (ch != CH_COLON) begin
                    r_vld     = 1'b1;
                    mode_next = MODE_ERR;
                    r_kind    = KIND_ERR;
                    r_err     = ERR_LINE;
                end else begin
                    pos_next    = 10'd1;
                    count_next  = 8'd0;
                    off_hi_next = 8'd0;
                    kind_next   = 8'd0;
                    sum_next    = 8'd0;
                    hold_next   = 4'd0;
                    field_next  = 32'd0;
                end
            end else if (pos_reg >= full_pos) begin
                // trailing text after the checksum is dropped
                pos_next = pos_reg;
            end else if (!hex_info[4]) begin
                r_vld     = 1'b1;
                mode_next = MODE_ERR;
                r_kind    = KIND_ERR;
                r_err     = ERR_HEX;
            end else begin
                pos_next = pos_reg + 10'd1;
                if (pos_reg >= 10'd9 && pos_reg <= data_end) begin
                    field_next = {field_reg[27:0], hex_info[3:0]};
                end
                if (pos_reg[0]) begin
                    hold_next = hex_info[3:0];
                end else begin
                    sum_next = sum_reg + byte_val;
                    if (pos_reg == 10'd2) begin
                        count_next = byte_val;
                    end else if (pos_reg == 10'd4) begin
                        off_hi_next = byte_val;
                    end else if (pos_reg == 10'd6) begin
                        // record start address, advanced by one for each data byte
                        cur_addr_next = base_reg + {16'd0, off_hi_reg, byte_val};
                    end else if (pos_reg == 10'd8) begin
                        kind_next = byte_val;
                    end else if (pos_reg >= 10'd10 && pos_reg <= data_end
                                 && kind_reg == REC_DATA) begin
                        r_vld         = 1'b1;
                        r_kind        = KIND_DATA;
                        r_data        = byte_val;
                        r_addr        = cur_addr_reg;
                        r_bs          = !run_open_reg || (cur_addr_reg != expect_reg);
                        run_open_next = 1'b1;
                        expect_next   = addr_inc;
                        cur_addr_next = addr_inc;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            mode_reg     <= MODE_RUN;
            pos_reg      <= 10'd0;
            count_reg    <= 8'd0;
            off_hi_reg   <= 8'd0;
            kind_reg     <= 8'd0;
            sum_reg      <= 8'd0;
            hold_reg     <= 4'd0;
            field_reg    <= 32'd0;
            base_reg     <= 32'd0;
            cur_addr_reg <= 32'd0;
            expect_reg   <= 32'd0;
            run_open_reg <= 1'b0;
            start_reg    <= 32'd0;
        end else if (fire) begin
            mode_reg     <= mode_next;
            pos_reg      <= pos_next;
            count_reg    <= count_next;
            off_hi_reg   <= off_hi_next;
            kind_reg     <= kind_next;
            sum_reg      <= sum_next;
            hold_reg     <= hold_next;
            field_reg    <= field_next;
            base_reg     <= base_next;
            cur_addr_reg <= cur_addr_next;
            expect_reg   <= expect_next;
            run_open_reg <= run_open_next;
            start_reg    <= start_next;
        end
    end

    assign stat.res_vld = r_vld;
    assign stat.mode    = mode_reg;

    assign res.kind         = r_kind;
    assign res.data_byte    = r_data;
    assign res.byte_address = r_addr;
    assign res.block_start  = r_bs;
    assign res.rec_type     = r_type;
    assign res.start_addr   = start_next;
    assign res.err_code     = r_err;

endmodule

[src/ihexp_out_reg.sv]
// result register toward the output channel
module ihexp_out_reg
    import ihexp_pkg::*;
(
    input  logic    clk,
    input  logic    rstn,
    input  logic    load,
    input  result_t res_in,
    input  logic    m_ready,
    output logic    m_valid,
    output result_t res_out
);

    logic    vld_reg, vld_next;
    result_t res_reg;

    always_comb begin
        vld_next = vld_reg;
        if (load) begin
            vld_next = 1'b1;
        end else if (m_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

    assign m_valid = vld_reg;
    assign res_out = res_reg;

endmodule

[src/intel_hex_record_parser_core.sv]
// intel hex record parser: one character per transaction, at most one result each
// flow: an accepted character waits in the input register until it is parsed; its result is then registered
// throughput: one character per cycle while m_ready stays high
// the input register and the result register decouple the two channels
// reset (aresetn low, synchronous): parser running, expecting a line start, all parser state zero
`include "intel_hex_record_parser_core_assert.svh"
module intel_hex_record_parser_core
    import ihexp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ch,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_data_byte,
    output logic [31:0] m_byte_address,
    output logic        m_block_start,
    output logic [7:0]  m_rec_type,
    output logic [31:0] m_start_addr,
    output logic [2:0]  m_err_code
);

    logic       in_vld_reg, in_vld_next;
    logic [7:0] in_ch_reg;
    logic       fire;
    eng_stat_t  stat;
    result_t    eng_res;
    result_t    out_res;

    // parse when the result register can take whatever this character produces
    assign fire    = in_vld_reg && (!m_valid || m_ready);
    assign s_ready = !in_vld_reg || fire;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
        end else if (fire) begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_ch_reg <= s_ch;
        end
    end

    ihexp_engine u_engine (
        .clk  (aclk),
        .rstn (aresetn),
        .fire (fire),
        .ch   (in_ch_reg),
        .stat (stat),
        .res  (eng_res)
    );

    ihexp_out_reg u_out_reg (
        .clk     (aclk),
        .rstn    (aresetn),
        .load    (fire && stat.res_vld),
        .res_in  (eng_res),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .res_out (out_res)
    );

    assign m_kind         = out_res.kind;
    assign m_data_byte    = out_res.data_byte;
    assign m_byte_address = out_res.byte_address;
    assign m_block_start  = out_res.block_start;
    assign m_rec_type     = out_res.rec_type;
    assign m_start_addr   = out_res.start_addr;
    assign m_err_code     = out_res.err_code;

    `IHEXP_ASSERT_IMP(a_data_clean, aclk, aresetn, m_valid && m_kind == KIND_DATA, m_rec_type == 8'd0 && m_err_code == ERR_NONE, "data result carries type or error")
    `IHEXP_ASSERT_IMP(a_err_coded, aclk, aresetn, m_valid && m_kind == KIND_ERR, m_err_code != ERR_NONE && m_byte_address == 32'd0, "error result without a code")
    `IHEXP_ASSERT_IMP(a_quiet_after_stop, aclk, aresetn, stat.mode != MODE_RUN, !stat.res_vld, "result produced after end or error")
    `IHEXP_ASSERT_NXT(a_stall_hold, aclk, aresetn, in_vld_reg && !fire, in_vld_reg && $stable(in_ch_reg), "held character lost during stall")

endmodule

[tb/ihexp_result_checker.sv]
// checker for the intel hex record parser: predicts each result and compares it
module ihexp_result_checker
    import ihexp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_ch,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_kind,
    input  logic [7:0]  m_data_byte,
    input  logic [31:0] m_byte_address,
    input  logic        m_block_start,
    input  logic [7:0]  m_rec_type,
    input  logic [31:0] m_start_addr,
    input  logic [2:0]  m_err_code,
    output int          pending_count,
    output int          fail_count
);

    // parser state as the predictor sees it
    logic [1:0]  pmode;
    logic [9:0]  pos;
    logic [7:0]  cnt;
    logic [15:0] ofs;
    logic [7:0]  rtype;
    logic [7:0]  csum;
    logic [3:0]  hi_nib;
    logic [31:0] fval;
    logic [31:0] base;
    logic [31:0] next_addr;
    logic        run_valid;
    logic [31:0] start_lin;

    result_t expected_results[$];
    int      fail_total = 0;

    assign fail_count = fail_total;

    function automatic string show(input result_t r);
        return $sformatf("kind=%0d data=%02h addr=%08h bs=%0d type=%02h start=%08h err=%0d",
                         r.kind, r.data_byte, r.byte_address, r.block_start, r.rec_type,
                         r.start_addr, r.err_code);
    endfunction

    // advance the parser by one character, returns 1 when a result is due
    function automatic bit parse_char(input logic [7:0] c, output result_t r);
        int         full_len;
        int         data_last;
        int         p;
        int         nib;
        bit         has;
        logic [2:0] errc;
        logic [7:0] b;
        logic [31:0] addr;
        r = '0;
        has = 1'b0;
        errc = ERR_NONE;
        full_len = 11 + 2 * int'(cnt);
        data_last = 8 + 2 * int'(cnt);
        if (pmode != MODE_RUN) begin
            has = 1'b0;
        end else if (c == CH_NL) begin
            if (pos == 0) errc = ERR_LINE;
            else if (int'(pos) < full_len) errc = ERR_SHORT;
            else if (csum != 8'h00) errc = ERR_CHECKSUM;
            else begin
                pos = '0;
                if (rtype == REC_EXT_SEG || rtype == REC_START_SEG) begin
                    errc = ERR_TYPE;
                end else begin
                    has = 1'b1;
                    r.rec_type = rtype;
                    if (rtype == REC_EOF) begin
                        pmode = MODE_DONE;
                        r.kind = KIND_EOF;
                    end else begin
                        r.kind = KIND_REC;
                        if (rtype == REC_EXT_LIN) base = fval << 16;
                        if (rtype == REC_START_LIN) start_lin = fval;
                    end
                end
            end
        end else if (pos == 0) begin
            if (c != CH_COLON) begin
                errc = ERR_LINE;
            end else begin
                pos = 10'd1;
                cnt = '0;
                ofs = '0;
                rtype = '0;
                csum = '0;
                hi_nib = '0;
                fval = '0;
            end
        end else if (int'(pos) < full_len) begin
            if (c >= CH_0 && c <= CH_9) nib = int'(c - CH_0);
            else if (c >= CH_UA && c <= CH_UF) nib = int'(c - CH_UA) + 10;
            else if (c >= CH_LA && c <= CH_LF) nib = int'(c - CH_LA) + 10;
            else nib = -1;
            if (nib < 0) begin
                errc = ERR_HEX;
            end else begin
                p = int'(pos);
                pos = pos + 10'd1;
                // data digits feed the 32-bit field value for base and start records
                if (p >= 9 && p <= data_last) fval = {fval[27:0], 4'(nib)};
                if (p % 2 == 1) begin
                    hi_nib = 4'(nib);
                end else begin
                    b = {hi_nib, 4'(nib)};
                    csum = csum + b;
                    if (p == 2) cnt = b;
                    else if (p == 4) ofs = {b, 8'h00};
                    else if (p == 6) ofs[7:0] = b;
                    else if (p == 8) rtype = b;
                    else if (p >= 10 && p <= data_last && rtype == REC_DATA) begin
                        addr = base + 32'(ofs) + 32'((p - 10) >> 1);
                        r.block_start = !run_valid || addr != next_addr;
                        run_valid = 1'b1;
                        next_addr = addr + 32'd1;
                        has = 1'b1;
                        r.kind = KIND_DATA;
                        r.data_byte = b;
                        r.byte_address = addr;
                    end
                end
            end
        end
        // past the checksum everything up to the newline is dropped
        if (errc != ERR_NONE) begin
            pmode = MODE_ERR;
            has = 1'b1;
            r.kind = KIND_ERR;
            r.err_code = errc;
        end
        r.start_addr = start_lin;
        return has;
    endfunction

    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (!aresetn) begin
            pmode = MODE_RUN;
            pos = '0;
            cnt = '0;
            ofs = '0;
            rtype = '0;
            csum = '0;
            hi_nib = '0;
            fval = '0;
            base = '0;
            next_addr = '0;
            run_valid = 1'b0;
            start_lin = '0;
            expected_results.delete();
            pending_count <= 0;
        end else begin
            if (m_valid && m_ready) begin
                got.kind = m_kind;
                got.data_byte = m_data_byte;
                got.byte_address = m_byte_address;
                got.block_start = m_block_start;
                got.rec_type = m_rec_type;
                got.start_addr = m_start_addr;
                got.err_code = m_err_code;
                if (expected_results.size() == 0) begin
                    if (fail_total < 10) $display("unexpected result: %s", show(got));
                    fail_total++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                        got.byte_address !== want.byte_address ||
                        got.block_start !== want.block_start ||
                        got.rec_type !== want.rec_type ||
                        got.start_addr !== want.start_addr ||
                        got.err_code !== want.err_code) begin
                        if (fail_total < 10) begin
                            $display("result mismatch: expected %s", show(want));
                            $display("                 actual   %s", show(got));
                        end
                        fail_total++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (parse_char(s_ch, want)) expected_results = {expected_results, want};
            end
            pending_count <= expected_results.size();
        end
    end

endmodule

[tb/intel_hex_record_parser_core_tb.sv]
// testbench top for the intel hex record parser: hex text stimulus and verdict
module intel_hex_record_parser_core_tb
    import ihexp_pkg::*;
;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_CHARS = 550;
    localparam int DRAIN_CYCLES = 16;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_ch;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_kind;
    logic [7:0]  m_data_byte;
    logic [31:0] m_byte_address;
    logic        m_block_start;
    logic [7:0]  m_rec_type;
    logic [31:0] m_start_addr;
    logic [2:0]  m_err_code;

    int pending_count;
    int fail_count;
    int cycle_count = 0;

    logic [7:0] line_buf[$];
    logic [7:0] payload[$];
    bit         send_burst = 1'b0;
    int         sent_chars = 0;

    intel_hex_record_parser_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_ch           (s_ch),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_data_byte    (m_data_byte),
        .m_byte_address (m_byte_address),
        .m_block_start  (m_block_start),
        .m_rec_type     (m_rec_type),
        .m_start_addr   (m_start_addr),
        .m_err_code     (m_err_code)
    );

    ihexp_result_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_ch           (s_ch),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_data_byte    (m_data_byte),
        .m_byte_address (m_byte_address),
        .m_block_start  (m_block_start),
        .m_rec_type     (m_rec_type),
        .m_start_addr   (m_start_addr),
        .m_err_code     (m_err_code),
        .pending_count  (pending_count),
        .fail_count     (fail_count)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[intel_hex_record_parser_core] ERROR");
        $finish;
    end

    // mostly short gaps, a few long ones, none at all in a burst
    function automatic int idle_length(input bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_char(input logic [7:0] c);
        int gap;
        if (sent_chars % 64 == 0) send_burst = ($urandom_range(0, 3) == 0);
        sent_chars++;
        gap = idle_length(send_burst);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_ch <= c;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_line();
        foreach (line_buf[i]) send_char(line_buf[i]);
        line_buf.delete();
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return CH_0 + v;
        return (($urandom_range(0, 1) == 1) ? CH_LA : CH_UA) + v - 8'd10;
    endfunction

    task automatic push_hex_byte(input logic [7:0] b);
        line_buf = {line_buf, hex_char(b[7:4])};
        line_buf = {line_buf, hex_char(b[3:0])};
    endtask

    task automatic fill_payload(input int n);
        payload.delete();
        repeat (n) payload = {payload, 8'($urandom_range(0, 255))};
    endtask

    // one record from the current payload, checksum optionally corrupted by sum_xor
    task automatic build_record(input logic [7:0] rtype, input logic [15:0] ofs,
                                input logic [7:0] sum_xor);
        logic [7:0] sum;
        line_buf.delete();
        line_buf = {line_buf, CH_COLON};
        sum = 8'(payload.size()) + ofs[15:8] + ofs[7:0] + rtype;
        push_hex_byte(8'(payload.size()));
        push_hex_byte(ofs[15:8]);
        push_hex_byte(ofs[7:0]);
        push_hex_byte(rtype);
        foreach (payload[i]) begin
            push_hex_byte(payload[i]);
            sum = sum + payload[i];
        end
        push_hex_byte((8'h00 - sum) ^ sum_xor);
    endtask

    // any byte but a newline
    task automatic add_trailing(input int n);
        logic [7:0] c;
        repeat (n) begin
            c = 8'($urandom_range(0, 254));
            if (c >= CH_NL) c = c + 8'd1;
            line_buf = {line_buf, c};
        end
    endtask

    task automatic record_line(input logic [7:0] rtype, input logic [15:0] ofs,
                               input int trail);
        build_record(rtype, ofs, 8'h00);
        add_trailing(trail);
        line_buf = {line_buf, CH_NL};
        send_line();
    endtask

    // receiver side
    initial begin
        int  hold;
        bit  held_off;
        bit  burst;
        held_off = 1'b0;
        burst = 1'b0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            // one long hold-off so the block fills up and back-pressures its input
            if (!held_off && cycle_count >= 300) begin
                m_ready <= 1'b0;
                repeat (200) @(posedge aclk);
                held_off = 1'b1;
            end
            if ($urandom_range(0, 15) == 0) burst = ($urandom_range(0, 2) == 0);
            hold = idle_length(burst);
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    // sender side
    initial begin
        int          pick;
        int          n;
        int          random_chars;
        logic [7:0]  c;
        logic [7:0]  rtype;
        logic [15:0] ofs;
        logic [15:0] follow_ofs;
        s_valid <= 1'b0;
        s_ch <= 8'h00;
        aresetn <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // opening records: run start, empty data record, run continuation, address wrap, start record,
        // long base record, empty base and start records, unknown type
        payload = '{8'h00, 8'hFF};
        record_line(REC_DATA, 16'h0000, 0);
        payload.delete();
        record_line(REC_DATA, 16'h1234, 0);
        payload = '{8'hA5};
        record_line(REC_DATA, 16'h0002, 0);
        payload = '{8'hFF, 8'hFF};
        record_line(REC_EXT_LIN, 16'h0000, 0);
        payload = '{8'h11, 8'h22, 8'h33, 8'h44};
        record_line(REC_DATA, 16'hFFFE, 0);
        payload = '{8'h12, 8'h34, 8'h56, 8'h78};
        record_line(REC_START_LIN, 16'h0000, 0);
        fill_payload(6);
        record_line(REC_EXT_LIN, 16'hFFFF, 0);
        payload.delete();
        record_line(REC_START_LIN, 16'h0000, 0);
        payload = '{8'h5A};
        record_line(8'hFF, 16'hFFFF, 5);
        payload.delete();
        record_line(REC_EXT_LIN, 16'h0000, 0);
        wait_drained();

        random_chars = 0;
        follow_ofs = 16'h0000;
        while (random_chars < RANDOM_CHARS) begin
            pick = $urandom_range(0, 99);
            ofs = 16'($urandom_range(0, 16'hFFFF));
            if (pick < 60) begin
                n = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 16);
                fill_payload(n);
                if ($urandom_range(0, 1) == 1) ofs = follow_ofs;
                rtype = REC_DATA;
                follow_ofs = ofs + 16'(n);
            end else if (pick < 72) begin
                fill_payload(($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : 2);
                if ($urandom_range(0, 3) == 0) begin
                    c = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
                    foreach (payload[i]) payload[i] = c;
                end
                rtype = REC_EXT_LIN;
            end else if (pick < 80) begin
                fill_payload(($urandom_range(0, 4) == 0) ? $urandom_range(0, 8) : 4);
                rtype = REC_START_LIN;
            end else begin
                fill_payload($urandom_range(0, 4));
                rtype = 8'($urandom_range(6, 255));
                if ($urandom_range(0, 4) == 0) begin
                    rtype = REC_DATA;
                    payload.delete();
                end
            end
            build_record(rtype, ofs, 8'h00);
            if ($urandom_range(0, 4) == 0) add_trailing($urandom_range(1, 6));
            line_buf = {line_buf, CH_NL};
            random_chars += line_buf.size();
            send_line();
        end

        // the closing line: end of file, or one of the faults that stop parsing
        pick = $urandom_range(0, 9);
        if (pick <= 3) begin
            fill_payload(($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0);
            build_record(REC_EOF, 16'(($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000),
                         8'h00);
            if ($urandom_range(0, 2) == 0) add_trailing($urandom_range(1, 4));
            // without its newline the record is never judged
            if ($urandom_range(0, 3) != 0) line_buf = {line_buf, CH_NL};
        end else if (pick == 4) begin
            line_buf.delete();
            do c = 8'($urandom_range(0, 255)); while (c == CH_COLON || c == CH_NL);
            line_buf = {line_buf, c};
        end else if (pick == 5) begin
            line_buf.delete();
            line_buf = {line_buf, CH_NL};
        end else if (pick == 6) begin
            fill_payload($urandom_range(0, 4));
            build_record(REC_DATA, 16'($urandom_range(0, 16'hFFFF)), 8'h00);
            do begin
                c = 8'($urandom_range(0, 255));
            end while ((c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UF) ||
                       (c >= CH_LA && c <= CH_LF) || c == CH_NL);
            line_buf[$urandom_range(1, line_buf.size() - 1)] = c;
            line_buf = {line_buf, CH_NL};
        end else if (pick == 7) begin
            fill_payload($urandom_range(0, 4));
            build_record(REC_DATA, 16'($urandom_range(0, 16'hFFFF)), 8'h00);
            n = $urandom_range(1, line_buf.size() - 1);
            while (line_buf.size() > n) void'(line_buf.pop_back());
            line_buf = {line_buf, CH_NL};
        end else if (pick == 8) begin
            fill_payload($urandom_range(0, 4));
            build_record(REC_DATA, 16'($urandom_range(0, 16'hFFFF)),
                         8'($urandom_range(1, 255)));
            line_buf = {line_buf, CH_NL};
        end else begin
            fill_payload($urandom_range(0, 4));
            build_record((($urandom_range(0, 1) == 1) ? REC_EXT_SEG : REC_START_SEG),
                         16'($urandom_range(0, 16'hFFFF)), 8'h00);
            line_buf = {line_buf, CH_NL};
        end
        send_line();

        // once parsing has stopped nothing more may come out
        repeat (16) send_char(8'($urandom_range(0, 255)));

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("[intel_hex_record_parser_core] OK");
        else
            $display("[intel_hex_record_parser_core] ERROR");
        $finish;
    end

endmodule
